// ===== hw/rtl/tpq_pkg.sv =====
// shared types, codes and constants of the three level ticket priority queue
package tpq_pkg;

   localparam int CAPACITY = 16;
   localparam int ID_W     = 34;
   localparam int PRIO_W   = 2;
   localparam int STAMP_W  = 32;
   localparam int COUNT_W  = 5;

   typedef enum logic [1:0] {
      CMD_REGISTER = 2'd0,
      CMD_SET_PRIO = 2'd1,
      CMD_SERVE    = 2'd2,
      CMD_LOOKUP   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_DUP       = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_EMPTY     = 3'd3,
      ST_FULL      = 3'd4,
      ST_BAD_PRIO  = 3'd5
   } status_type;

   localparam logic [PRIO_W-1:0] PRIO_LOW     = 2'd2;
   localparam logic [PRIO_W-1:0] PRIO_INVALID = 2'd3;

   typedef struct packed {
      cmd_type             command;
      logic [ID_W-1:0]     ticket_id;
      logic [PRIO_W-1:0]   new_priority;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [ID_W-1:0]     found_id;
      logic [PRIO_W-1:0]   found_priority;
      logic [STAMP_W-1:0]  found_stamp;
      logic [COUNT_W-1:0]  waiting_count;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [PRIO_W-1:0]   prio;
      logic [STAMP_W-1:0]  stamp;
   } entry_type;

   typedef struct packed {
      logic start;
      logic issue;
      logic commit;
   } ctl_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic rsp_free;
   } dp_status_type;

endpackage

// ===== hw/rtl/tpq_controller.sv =====
// command sequencer: accept, table scan, finish and commit steps
module tpq_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tpq_pkg::dp_status_type dp_status,
   output tpq_pkg::ctl_cmd_type   ctl_cmd
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_FINISH = 4'b0100,
      S_COMMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in       = state_ff;
      ctl_cmd.start  = 1'b0;
      ctl_cmd.issue  = 1'b0;
      ctl_cmd.commit = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl_cmd.start = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            ctl_cmd.issue = 1'b1;
            if (dp_status.scan_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (dp_status.rsp_free) begin
               ctl_cmd.commit = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/tpq_datapath.sv =====
// ticket table memory, scan trackers, commit logic and response register
module tpq_datapath #(
   parameter int CAPACITY = tpq_pkg::CAPACITY
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tpq_pkg::ctl_cmd_type   ctl_cmd,
   output tpq_pkg::dp_status_type dp_status,
   input  tpq_pkg::req_type       req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tpq_pkg::rsp_type       rsp_word
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   tpq_pkg::entry_type mem [CAPACITY];

   tpq_pkg::req_type   req_ff;
   logic [IW-1:0]      scan_ff;
   tpq_pkg::entry_type rd_entry_ff;
   logic               rd_valid_ff;
   logic               rd_live_ff;
   logic [IW-1:0]      rd_idx_ff;

   logic               match_hit_ff, match_hit_in;
   tpq_pkg::entry_type match_entry_ff;
   logic [IW-1:0]      rd_idx_match_ff;
   logic               free_hit_ff, free_hit_in;
   logic [IW-1:0]      free_idx_ff;
   logic               best_hit_ff, best_hit_in;
   logic [IW-1:0]      best_idx_ff;
   tpq_pkg::entry_type best_entry_ff;

   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [tpq_pkg::STAMP_W-1:0] arrival_ff, arrival_in;
   tpq_pkg::rsp_type    rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                        rd_match, rd_free, rd_better, rd_older;
   logic [tpq_pkg::STAMP_W-1:0] stamp_diff;
   logic                        do_write, set_valid, clr_valid;
   tpq_pkg::entry_type          wr_entry;
   logic [IW-1:0]               wr_idx;

   // scan evaluation of the entry read in the previous cycle
   assign stamp_diff = rd_entry_ff.stamp - best_entry_ff.stamp;
   assign rd_older   = stamp_diff[tpq_pkg::STAMP_W-1];
   assign rd_match   = rd_live_ff && rd_valid_ff && !match_hit_ff
                       && (rd_entry_ff.id == req_ff.ticket_id);
   assign rd_free    = rd_live_ff && !rd_valid_ff && !free_hit_ff;
   assign rd_better  = rd_live_ff && rd_valid_ff
                       && (!best_hit_ff || (rd_entry_ff.prio < best_entry_ff.prio)
                           || ((rd_entry_ff.prio == best_entry_ff.prio) && rd_older));

   assign match_hit_in = ctl_cmd.start ? 1'b0 : (match_hit_ff || rd_match);
   assign free_hit_in  = ctl_cmd.start ? 1'b0 : (free_hit_ff || rd_free);
   assign best_hit_in  = ctl_cmd.start ? 1'b0 : (best_hit_ff || rd_better);

   // command decode at commit
   always_comb begin
      rsp_in           = '0;
      rsp_in.status    = tpq_pkg::ST_OK;
      do_write         = 1'b0;
      set_valid        = 1'b0;
      clr_valid        = 1'b0;
      wr_idx           = free_idx_ff;
      wr_entry.id      = req_ff.ticket_id;
      wr_entry.prio    = tpq_pkg::PRIO_LOW;
      wr_entry.stamp   = arrival_ff;
      count_in         = count_ff;
      arrival_in       = arrival_ff;
      unique case (req_ff.command)
         tpq_pkg::CMD_REGISTER: begin
            if (match_hit_ff) begin
               rsp_in.status = tpq_pkg::ST_DUP;
            end else if (!free_hit_ff) begin
               rsp_in.status = tpq_pkg::ST_FULL;
            end else begin
               do_write   = 1'b1;
               set_valid  = 1'b1;
               count_in   = count_ff + 1'b1;
               arrival_in = arrival_ff + 1'b1;
            end
         end
         tpq_pkg::CMD_SET_PRIO: begin
            if (!match_hit_ff) begin
               rsp_in.status = tpq_pkg::ST_NOT_FOUND;
            end else if (req_ff.new_priority == tpq_pkg::PRIO_INVALID) begin
               rsp_in.status = tpq_pkg::ST_BAD_PRIO;
            end else begin
               do_write       = 1'b1;
               wr_idx         = rd_idx_match_ff;
               wr_entry.prio  = req_ff.new_priority;
               wr_entry.stamp = match_entry_ff.stamp;
            end
         end
         tpq_pkg::CMD_SERVE: begin
            if (!best_hit_ff) begin
               rsp_in.status = tpq_pkg::ST_EMPTY;
            end else begin
               clr_valid             = 1'b1;
               count_in              = count_ff - 1'b1;
               rsp_in.found_id       = best_entry_ff.id;
               rsp_in.found_priority = best_entry_ff.prio;
               rsp_in.found_stamp    = best_entry_ff.stamp;
            end
         end
         tpq_pkg::CMD_LOOKUP: begin
            if (count_ff == '0) begin
               rsp_in.status = tpq_pkg::ST_EMPTY;
            end else if (!match_hit_ff) begin
               rsp_in.status = tpq_pkg::ST_NOT_FOUND;
            end else begin
               rsp_in.found_id       = match_entry_ff.id;
               rsp_in.found_priority = match_entry_ff.prio;
               rsp_in.found_stamp    = match_entry_ff.stamp;
            end
         end
         default: begin
            rsp_in.status = tpq_pkg::ST_OK;
         end
      endcase
      rsp_in.waiting_count = tpq_pkg::COUNT_W'(count_in);
   end

   always_comb begin
      valid_in = valid_ff;
      if (ctl_cmd.commit && set_valid) begin
         valid_in[free_idx_ff] = 1'b1;
      end
      if (ctl_cmd.commit && clr_valid) begin
         valid_in[best_idx_ff] = 1'b0;
      end
   end

   assign rsp_valid_in = ctl_cmd.commit || (rsp_valid_ff && rsp_stall);

   assign dp_status.scan_last = (scan_ff == IW'(CAPACITY - 1));
   assign dp_status.rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         count_ff     <= '0;
         arrival_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         rd_live_ff   <= 1'b0;
         match_hit_ff <= 1'b0;
         free_hit_ff  <= 1'b0;
         best_hit_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         rd_live_ff   <= ctl_cmd.issue;
         match_hit_ff <= match_hit_in;
         free_hit_ff  <= free_hit_in;
         best_hit_ff  <= best_hit_in;
         if (ctl_cmd.commit) begin
            valid_ff   <= valid_in;
            count_ff   <= count_in;
            arrival_ff <= arrival_in;
         end
      end
   end

   // table memory and payload registers
   always_ff @(posedge clock) begin
      if (ctl_cmd.commit && do_write) begin
         mem[wr_idx] <= wr_entry;
      end
      rd_entry_ff <= mem[scan_ff];
      rd_valid_ff <= valid_ff[scan_ff];
      rd_idx_ff   <= scan_ff;
      if (ctl_cmd.start) begin
         req_ff  <= req_word;
         scan_ff <= '0;
      end else if (ctl_cmd.issue) begin
         scan_ff <= scan_ff + 1'b1;
      end
      if (rd_match) begin
         match_entry_ff  <= rd_entry_ff;
         rd_idx_match_ff <= rd_idx_ff;
      end
      if (rd_free) begin
         free_idx_ff <= rd_idx_ff;
      end
      if (rd_better) begin
         best_entry_ff <= rd_entry_ff;
         best_idx_ff   <= rd_idx_ff;
      end
      if (ctl_cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   a_count_tracks_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == count_ff)
      else $error("held count differs from valid bits");

   a_commit_needs_free_output: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.commit |-> dp_status.rsp_free)
      else $error("commit while response register is occupied");

   a_commit_gives_response: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.commit |=> rsp_valid_ff)
      else $error("commit without response");

   a_table_stable_between_commits: assert property (@(posedge clock) disable iff (reset)
      !ctl_cmd.commit |=> ($stable(valid_ff) && $stable(arrival_ff)))
      else $error("table state changed outside commit");

endmodule

// ===== hw/rtl/three_level_ticket_priority_queue.sv =====
// top level of the three level ticket priority queue with first-come tiebreak
// a command word is accepted only in the idle state; req_stall holds off the next one until commit
// the table is scanned one entry per cycle through a single memory read port, then the commit step
// writes the new or changed entry and loads the response register once that register is free
// reset clears the valid bits, the held count, the arrival counter and the output valid flag
module three_level_ticket_priority_queue #(
   parameter int CAPACITY = tpq_pkg::CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tpq_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tpq_pkg::rsp_type rsp_word
);

   tpq_pkg::ctl_cmd_type   ctl_cmd;
   tpq_pkg::dp_status_type dp_status;

   tpq_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .ctl_cmd   (ctl_cmd)
   );

   tpq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctl_cmd   (ctl_cmd),
      .dp_status (dp_status),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

// ===== dv/three_level_ticket_priority_queue_tb.sv =====
// self-checking testbench for the three level ticket priority queue
module three_level_ticket_priority_queue_tb;

   localparam int RANDOM_WORDS    = 1080;
   localparam int CALM_WORDS      = 150;
   localparam int PHASE_WORDS     = 60;
   localparam int POOL_SIZE       = 24;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int LIMIT_CYCLES    = 400000;
   localparam int REPORT_LIMIT    = 10;

   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN
   } mix_type;

   class ticket_table_model;
      tpq_pkg::entry_type          slots [tpq_pkg::CAPACITY];
      bit                          held [tpq_pkg::CAPACITY];
      logic [tpq_pkg::STAMP_W-1:0] next_stamp;
      tpq_pkg::rsp_type            due_replies [$];
      int unsigned                 mismatches;
      int unsigned                 commands;
      int unsigned                 replies;
      int unsigned                 peak_held;
      int unsigned                 status_tally [6];

      function new();
         foreach (held[i]) begin
            held[i] = 1'b0;
            slots[i] = '0;
         end
         next_stamp = '0;
         mismatches = 0;
         commands = 0;
         replies = 0;
         peak_held = 0;
         foreach (status_tally[i]) status_tally[i] = 0;
      endfunction

      function int find_slot(logic [tpq_pkg::ID_W-1:0] id);
         for (int i = 0; i < tpq_pkg::CAPACITY; i++)
            if (held[i] && slots[i].id == id) return i;
         return -1;
      endfunction

      function int free_slot();
         for (int i = 0; i < tpq_pkg::CAPACITY; i++)
            if (!held[i]) return i;
         return -1;
      endfunction

      function bit stamp_older(logic [tpq_pkg::STAMP_W-1:0] a,
                               logic [tpq_pkg::STAMP_W-1:0] b);
         logic [tpq_pkg::STAMP_W-1:0] d;
         d = a - b;
         return d[tpq_pkg::STAMP_W-1];
      endfunction

      function int first_slot();
         int best;
         best = -1;
         for (int i = 0; i < tpq_pkg::CAPACITY; i++) begin
            if (!held[i]) continue;
            if (best < 0 || slots[i].prio < slots[best].prio ||
                (slots[i].prio == slots[best].prio &&
                 stamp_older(slots[i].stamp, slots[best].stamp)))
               best = i;
         end
         return best;
      endfunction

      function int unsigned held_count();
         int unsigned n;
         n = 0;
         foreach (held[i]) if (held[i]) n++;
         return n;
      endfunction

      function void take_command(tpq_pkg::req_type w);
         tpq_pkg::rsp_type r;
         int               k;
         r = '0;
         r.status = tpq_pkg::ST_OK;
         case (w.command)
            tpq_pkg::CMD_REGISTER: begin
               if (find_slot(w.ticket_id) >= 0) begin
                  r.status = tpq_pkg::ST_DUP;
               end else begin
                  k = free_slot();
                  if (k < 0) begin
                     r.status = tpq_pkg::ST_FULL;
                  end else begin
                     held[k] = 1'b1;
                     slots[k].id = w.ticket_id;
                     slots[k].prio = tpq_pkg::PRIO_LOW;
                     slots[k].stamp = next_stamp;
                     next_stamp = next_stamp + 1'b1;
                  end
               end
            end
            tpq_pkg::CMD_SET_PRIO: begin
               k = find_slot(w.ticket_id);
               if (k < 0) r.status = tpq_pkg::ST_NOT_FOUND;
               else if (w.new_priority == tpq_pkg::PRIO_INVALID)
                  r.status = tpq_pkg::ST_BAD_PRIO;
               else slots[k].prio = w.new_priority;
            end
            tpq_pkg::CMD_SERVE: begin
               k = first_slot();
               if (k < 0) begin
                  r.status = tpq_pkg::ST_EMPTY;
               end else begin
                  r.found_id = slots[k].id;
                  r.found_priority = slots[k].prio;
                  r.found_stamp = slots[k].stamp;
                  held[k] = 1'b0;
               end
            end
            default: begin
               if (held_count() == 0) begin
                  r.status = tpq_pkg::ST_EMPTY;
               end else begin
                  k = find_slot(w.ticket_id);
                  if (k < 0) begin
                     r.status = tpq_pkg::ST_NOT_FOUND;
                  end else begin
                     r.found_id = slots[k].id;
                     r.found_priority = slots[k].prio;
                     r.found_stamp = slots[k].stamp;
                  end
               end
            end
         endcase
         r.waiting_count = tpq_pkg::COUNT_W'(held_count());
         if (held_count() > peak_held) peak_held = held_count();
         status_tally[int'(r.status)]++;
         commands++;
         due_replies.push_back(r);
      endfunction

      function void report(string what, tpq_pkg::rsp_type want, tpq_pkg::rsp_type got);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("mismatch (%s) at %0t: want st=%0d id=%0h pr=%0d stamp=%0h n=%0d",
                     what, $realtime, want.status, want.found_id, want.found_priority,
                     want.found_stamp, want.waiting_count);
            $display("   got st=%0d id=%0h pr=%0d stamp=%0h n=%0d",
                     got.status, got.found_id, got.found_priority,
                     got.found_stamp, got.waiting_count);
         end
      endfunction

      function void check_reply(tpq_pkg::rsp_type got);
         tpq_pkg::rsp_type want;
         replies++;
         if (due_replies.size() == 0) begin
            report("unexpected word", '0, got);
            return;
         end
         want = due_replies.pop_front();
         if (got.status !== want.status || got.found_id !== want.found_id ||
             got.found_priority !== want.found_priority ||
             got.found_stamp !== want.found_stamp ||
             got.waiting_count !== want.waiting_count)
            report("field", want, got);
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   tpq_pkg::req_type req_word = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   tpq_pkg::rsp_type rsp_word;

   ticket_table_model        table_model = new();
   logic [tpq_pkg::ID_W-1:0] id_pool [POOL_SIZE];
   bit                       calm = 1'b0;
   bit                       hold_off_pending = 1'b0;
   int unsigned              cycle_count = 0;

   three_level_ticket_priority_queue u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) table_model.take_command(req_word);
         if (rsp_valid && !rsp_stall) table_model.check_reply(rsp_word);
      end
   end

   function automatic tpq_pkg::req_type make_word(tpq_pkg::cmd_type c,
                                                  logic [tpq_pkg::ID_W-1:0] id,
                                                  logic [tpq_pkg::PRIO_W-1:0] p);
      tpq_pkg::req_type w;
      w.command = c;
      w.ticket_id = id;
      w.new_priority = p;
      return w;
   endfunction

   function automatic logic [tpq_pkg::ID_W-1:0] random_id();
      logic [tpq_pkg::ID_W-1:0] v;
      v[31:0] = $urandom();
      v[tpq_pkg::ID_W-1:32] = 2'($urandom_range(0, 3));
      return v;
   endfunction

   task automatic send_word(input tpq_pkg::req_type w);
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 14);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic refresh_pool();
      foreach (id_pool[i]) begin
         if ($urandom_range(0, 2) == 0) id_pool[i] = tpq_pkg::ID_W'($urandom_range(0, 40));
         else id_pool[i] = random_id();
      end
   endtask

   task automatic send_random_word(input mix_type mix);
      int                       roll;
      tpq_pkg::cmd_type         c;
      logic [tpq_pkg::ID_W-1:0] id;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL: begin
            c = roll < 50 ? tpq_pkg::CMD_REGISTER : roll < 72 ? tpq_pkg::CMD_SET_PRIO :
                roll < 85 ? tpq_pkg::CMD_SERVE : tpq_pkg::CMD_LOOKUP;
         end
         MIX_DRAIN: begin
            c = roll < 15 ? tpq_pkg::CMD_REGISTER : roll < 30 ? tpq_pkg::CMD_SET_PRIO :
                roll < 80 ? tpq_pkg::CMD_SERVE : tpq_pkg::CMD_LOOKUP;
         end
         default: begin
            c = roll < 30 ? tpq_pkg::CMD_REGISTER : roll < 55 ? tpq_pkg::CMD_SET_PRIO :
                roll < 78 ? tpq_pkg::CMD_SERVE : tpq_pkg::CMD_LOOKUP;
         end
      endcase
      if ($urandom_range(0, 99) < 85) id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
      else id = random_id();
      send_word(make_word(c, id, tpq_pkg::PRIO_W'($urandom_range(0, 3))));
   endtask

   task automatic run_directed();
      logic [tpq_pkg::ID_W-1:0] top_id;
      top_id = '1;
      send_word(make_word(tpq_pkg::CMD_SERVE, random_id(), 2'd0));
      send_word(make_word(tpq_pkg::CMD_LOOKUP, '0, 2'd0));
      send_word(make_word(tpq_pkg::CMD_REGISTER, '0, 2'd3));
      send_word(make_word(tpq_pkg::CMD_REGISTER, top_id, 2'd0));
      send_word(make_word(tpq_pkg::CMD_REGISTER, '0, 2'd1));
      send_word(make_word(tpq_pkg::CMD_SET_PRIO, top_id, 2'd0));
      send_word(make_word(tpq_pkg::CMD_SET_PRIO, '0, tpq_pkg::PRIO_INVALID));
      send_word(make_word(tpq_pkg::CMD_SET_PRIO, tpq_pkg::ID_W'(77),
                          tpq_pkg::PRIO_INVALID));
      send_word(make_word(tpq_pkg::CMD_LOOKUP, tpq_pkg::ID_W'(77), 2'd0));
      send_word(make_word(tpq_pkg::CMD_LOOKUP, top_id, 2'd2));
      send_word(make_word(tpq_pkg::CMD_SET_PRIO, '0, 2'd1));
      for (int i = 0; i < tpq_pkg::CAPACITY - 2; i++)
         send_word(make_word(tpq_pkg::CMD_REGISTER,
                             i == 0 ? tpq_pkg::ID_W'(64'd9999999999)
                                    : tpq_pkg::ID_W'(1000 + i), 2'd0));
      send_word(make_word(tpq_pkg::CMD_REGISTER, tpq_pkg::ID_W'(5000), 2'd0));
      send_word(make_word(tpq_pkg::CMD_REGISTER, top_id, 2'd0));
      send_word(make_word(tpq_pkg::CMD_SERVE, '0, 2'd3));
      send_word(make_word(tpq_pkg::CMD_SERVE, top_id, 2'd0));
   endtask

   initial begin : rsp_side
      int span;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            span = $urandom_range(1, 14);
            repeat (span) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            span = $urandom_range(1, 16);
            repeat (span) @(posedge clock);
         end
      end
   end

   initial begin : req_side
      mix_type mix;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      hold_off_pending = 1'b1;
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i % PHASE_WORDS == 0) begin
            refresh_pool();
            mix = mix_type'($urandom_range(0, 2));
         end
         if (i >= RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
         send_random_word(mix);
      end
      req_valid <= 1'b0;
      while (table_model.due_replies.size() != 0) @(posedge clock);
      repeat (2 * tpq_pkg::CAPACITY + 6) @(posedge clock);
      if (table_model.due_replies.size() != 0) table_model.mismatches++;
      $display("covered %0d commands and %0d replies, peak occupancy %0d, %0d mismatches",
               table_model.commands, table_model.replies, table_model.peak_held,
               table_model.mismatches);
      $display("statuses: ok %0d dup %0d not-found %0d empty %0d full %0d bad-priority %0d",
               table_model.status_tally[0], table_model.status_tally[1],
               table_model.status_tally[2], table_model.status_tally[3],
               table_model.status_tally[4], table_model.status_tally[5]);
      if (table_model.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
